// ===== sv/tokf_pkg.sv =====
// Package for the TCP option kind finder: types, codes and the single-byte kind table.
package tokf_pkg;

   localparam int FIXED_HEADER_BYTES_DEF = 20;

   localparam logic [7:0] KIND_END_OF_LIST  = 8'd0;
   localparam logic [7:0] MIN_OPTION_LENGTH = 8'd2;

   typedef enum logic [1:0] {
      PHASE_KIND = 2'd0,
      PHASE_LEN  = 2'd1,
      PHASE_SKIP = 2'd2,
      PHASE_DONE = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      END_FOUND     = 2'd0,
      END_SCANNED   = 2'd1,
      END_LIST      = 2'd2,
      END_MALFORMED = 2'd3
   } end_reason_type;

   typedef struct packed {
      phase_type      phase;
      logic [7:0]     skip_remaining;
      end_reason_type outcome;
   } walk_state_type;

   localparam logic [7:0] WANTED_KIND_RESET = 8'd30;

   function automatic logic single_byte_kind(input logic [7:0] kind);
      logic result;
      begin
         case (kind)
            8'd1, 8'd11, 8'd12, 8'd13, 8'd16, 8'd17,
            8'd20, 8'd21, 8'd22, 8'd23, 8'd24, 8'd26: result = 1'b1;
            default: result = 1'b0;
         endcase
         return result;
      end
   endfunction

endpackage

// ===== sv/tokf_option_walker.sv =====
// Next-state logic for one byte of the TCP option list walk.
module tokf_option_walker (
   input  tokf_pkg::walk_state_type cur_state,
   input  logic [7:0]               option_byte,
   input  logic [7:0]               wanted_kind,
   output tokf_pkg::walk_state_type nxt_state
);
   import tokf_pkg::*;

   always_comb begin
      nxt_state = cur_state;
      case (cur_state.phase)
         PHASE_KIND: begin
            if (option_byte == wanted_kind) begin
               nxt_state.outcome = END_FOUND;
               nxt_state.phase   = PHASE_DONE;
            end else if (option_byte == KIND_END_OF_LIST) begin
               nxt_state.outcome = END_LIST;
               nxt_state.phase   = PHASE_DONE;
            end else if (!single_byte_kind(option_byte)) begin
               nxt_state.phase = PHASE_LEN;
            end
         end
         PHASE_LEN: begin
            if (option_byte < MIN_OPTION_LENGTH) begin
               nxt_state.outcome = END_MALFORMED;
               nxt_state.phase   = PHASE_DONE;
            end else begin
               nxt_state.skip_remaining = option_byte - MIN_OPTION_LENGTH;
               nxt_state.phase = (option_byte == MIN_OPTION_LENGTH) ? PHASE_KIND : PHASE_SKIP;
            end
         end
         PHASE_SKIP: begin
            nxt_state.skip_remaining = cur_state.skip_remaining - 8'd1;
            if (cur_state.skip_remaining == 8'd1) begin
               nxt_state.phase = PHASE_KIND;
            end
         end
         default: begin
            nxt_state = cur_state;
         end
      endcase
   end

endmodule

// ===== sv/tcp_option_kind_finder.sv =====
// Top level of the TCP option kind finder.
// Pipeline: a header item is registered on acceptance, and its result, if any, is registered
// in the result register once the output can advance.
// Throughput: one header byte per cycle while the result output is not stalled by rsp_ready.
// Reset: synchronous; clears the walk state, both pipeline stages and sets wanted kind to 30.
module tcp_option_kind_finder #(
   parameter int FIXED_HEADER_BYTES = tokf_pkg::FIXED_HEADER_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_header_byte,
   input  logic       req_start_of_header,
   input  logic [3:0] req_header_words,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_found,
   output logic [1:0] rsp_end_reason,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);
   import tokf_pkg::*;

   logic [7:0]     wanted_kind_ff;
   logic           s1_valid_ff;
   logic [7:0]     s1_byte_ff;
   logic           s1_start_ff;
   logic [3:0]     s1_words_ff;

   logic           active_ff, active_in;
   logic [5:0]     pos_ff, pos_in;
   logic [5:0]     hb_ff, hb_in;
   walk_state_type walk_ff, walk_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_found_ff, rsp_found_in;
   end_reason_type rsp_reason_ff, rsp_reason_in;

   logic           advance;
   logic           process;
   logic           eff_active;
   logic [5:0]     eff_pos;
   logic [5:0]     eff_hb;
   walk_state_type eff_walk;
   walk_state_type walked;
   logic           last_byte;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign process   = s1_valid_ff && advance;
   assign req_ready = !s1_valid_ff || advance;

   always_comb begin
      if (s1_start_ff) begin
         eff_active              = 1'b1;
         eff_pos                 = 6'd0;
         eff_hb                  = {s1_words_ff, 2'b00};
         eff_walk.phase          = PHASE_KIND;
         eff_walk.skip_remaining = 8'd0;
         eff_walk.outcome        = END_SCANNED;
      end else begin
         eff_active = active_ff;
         eff_pos    = pos_ff;
         eff_hb     = hb_ff;
         eff_walk   = walk_ff;
      end
   end

   tokf_option_walker u_walker (
      .cur_state   (eff_walk),
      .option_byte (s1_byte_ff),
      .wanted_kind (wanted_kind_ff),
      .nxt_state   (walked)
   );

   assign last_byte = ({1'b0, eff_pos} + 7'd1) >= {1'b0, eff_hb};

   always_comb begin
      active_in     = active_ff;
      pos_in        = pos_ff;
      hb_in         = hb_ff;
      walk_in       = walk_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_found_in  = rsp_found_ff;
      rsp_reason_in = rsp_reason_ff;
      if (process && eff_active) begin
         hb_in   = eff_hb;
         walk_in = eff_walk;
         if (eff_pos >= 6'(FIXED_HEADER_BYTES) && eff_pos < eff_hb) begin
            walk_in = walked;
         end
         if (last_byte) begin
            rsp_valid_in           = 1'b1;
            rsp_found_in           = (walk_in.outcome == END_FOUND);
            rsp_reason_in          = walk_in.outcome;
            active_in              = 1'b0;
            pos_in                 = 6'd0;
            walk_in.phase          = PHASE_KIND;
            walk_in.skip_remaining = 8'd0;
         end else begin
            active_in = 1'b1;
            pos_in    = eff_pos + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_kind_ff         <= WANTED_KIND_RESET;
         s1_valid_ff            <= 1'b0;
         active_ff              <= 1'b0;
         pos_ff                 <= 6'd0;
         hb_ff                  <= 6'd0;
         walk_ff.phase          <= PHASE_KIND;
         walk_ff.skip_remaining <= 8'd0;
         walk_ff.outcome        <= END_SCANNED;
         rsp_valid_ff           <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            wanted_kind_ff <= csr_wr_data;
         end
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         active_ff    <= active_in;
         pos_ff       <= pos_in;
         hb_ff        <= hb_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_byte_ff  <= req_header_byte;
         s1_start_ff <= req_start_of_header;
         s1_words_ff <= req_header_words;
      end
      rsp_found_ff  <= rsp_found_in;
      rsp_reason_ff <= rsp_reason_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_end_reason = rsp_reason_ff;

   a_found_matches_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_found_ff == (rsp_reason_ff == END_FOUND)))
      else $error("found flag disagrees with end reason");

   a_idle_state_clear: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (pos_ff == 6'd0 && walk_ff.phase == PHASE_KIND
                      && walk_ff.skip_remaining == 8'd0))
      else $error("walk state not cleared while idle");

   a_pos_in_header: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (pos_ff < hb_ff))
      else $error("byte position beyond header length");

   a_skip_nonzero: assert property (@(posedge clock) disable iff (reset)
      (walk_ff.phase == PHASE_SKIP) |-> (walk_ff.skip_remaining != 8'd0))
      else $error("skipping with no bytes left");

endmodule

// ===== tb/tcp_option_kind_finder_test.sv =====
// Testbench for the TCP option kind finder: directed and random headers checked against a model.
module tcp_option_kind_finder_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tokf_pkg::*;

   localparam int STALL_CYCLES = 300;

   typedef logic [7:0] byte_q_type[$];

   typedef struct packed {
      logic           found;
      end_reason_type reason;
   } verdict_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_header_byte = 8'd0;
   logic       req_start_of_header = 1'b0;
   logic [3:0] req_header_words = 4'd0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_found;
   logic [1:0] rsp_end_reason;
   logic       csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = 8'd0;

   // receiver hold-off request, toggled by the test side
   logic stall_req = 1'b0;
   logic stall_ack = 1'b0;
   int   stall_left = 0;

   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int items_sent = 0;
   int bad_results = 0;

   verdict_type pending_verdicts[$];

   // model state
   logic [7:0]     want_kind = WANTED_KIND_RESET;
   logic [5:0]     hdr_pos = 6'd0;
   logic [5:0]     hdr_len = 6'd0;
   phase_type      walk_phase = PHASE_KIND;
   logic [7:0]     skip_left = 8'd0;
   end_reason_type walk_outcome = END_SCANNED;
   logic           hdr_open = 1'b0;

   tcp_option_kind_finder i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_header_byte     (req_header_byte),
      .req_start_of_header (req_start_of_header),
      .req_header_words    (req_header_words),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_found           (rsp_found),
      .rsp_end_reason      (rsp_end_reason),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   always #5ns clock = ~clock;

   initial begin
      #2ms;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic logic one_byte_option(input logic [7:0] kind);
      case (kind)
         8'd1, 8'd11, 8'd12, 8'd13, 8'd16, 8'd17, 8'd26: return 1'b1;
         default: return kind >= 8'd20 && kind <= 8'd24;
      endcase
   endfunction

   function automatic void walk_header_byte(input logic [7:0] hbyte, input logic sof,
                                            input logic [3:0] words);
      verdict_type v;
      if (sof) begin
         hdr_open = 1'b1;
         hdr_pos = 6'd0;
         hdr_len = {words, 2'b00};
         walk_phase = PHASE_KIND;
         skip_left = 8'd0;
         walk_outcome = END_SCANNED;
      end
      if (!hdr_open)
         return;
      if (hdr_pos >= FIXED_HEADER_BYTES_DEF && hdr_pos < hdr_len) begin
         case (walk_phase)
            PHASE_KIND: begin
               if (hbyte == want_kind) begin
                  walk_outcome = END_FOUND;
                  walk_phase = PHASE_DONE;
               end else if (hbyte == KIND_END_OF_LIST) begin
                  walk_outcome = END_LIST;
                  walk_phase = PHASE_DONE;
               end else if (!one_byte_option(hbyte)) begin
                  walk_phase = PHASE_LEN;
               end
            end
            PHASE_LEN: begin
               if (hbyte < MIN_OPTION_LENGTH) begin
                  walk_outcome = END_MALFORMED;
                  walk_phase = PHASE_DONE;
               end else begin
                  skip_left = hbyte - MIN_OPTION_LENGTH;
                  walk_phase = (skip_left == 8'd0) ? PHASE_KIND : PHASE_SKIP;
               end
            end
            PHASE_SKIP: begin
               skip_left = skip_left - 8'd1;
               if (skip_left == 8'd0)
                  walk_phase = PHASE_KIND;
            end
            default: ;
         endcase
      end
      if ({1'b0, hdr_pos} + 7'd1 >= {1'b0, hdr_len}) begin
         v.found = (walk_outcome == END_FOUND);
         v.reason = walk_outcome;
         pending_verdicts.push_back(v);
         hdr_open = 1'b0;
         hdr_pos = 6'd0;
         walk_phase = PHASE_KIND;
         skip_left = 8'd0;
      end else begin
         hdr_pos = hdr_pos + 6'd1;
      end
   endfunction

   function automatic void report_bad(input string msg);
      bad_results++;
      if (bad_results <= 10)
         $display("mismatch: %s", msg);
   endfunction

   always @(posedge clock) begin
      if (stall_req != stall_ack) begin
         stall_ack <= stall_req;
         stall_left <= STALL_CYCLES;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      verdict_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            report_bad($sformatf("result with none expected: found %0b reason %0d",
                                 rsp_found, rsp_end_reason));
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_found !== want.found || rsp_end_reason !== want.reason)
               report_bad($sformatf("expected found %0b reason %0d, got found %0b reason %0d",
                                    want.found, want.reason, rsp_found, rsp_end_reason));
         end
      end
   end

   task automatic send_item(input logic [7:0] hbyte, input logic sof, input logic [3:0] words);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_header_byte <= hbyte;
      req_start_of_header <= sof;
      req_header_words <= words;
      do @(posedge clock); while (!req_ready);
      walk_header_byte(hbyte, sof, words);
      items_sent++;
   endtask

   task automatic send_header(input logic [3:0] words, input byte_q_type body);
      foreach (body[i])
         send_item(body[i], i == 0, (i == 0) ? words : 4'($urandom()));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_verdicts.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_wanted_kind(input logic [7:0] kind);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= kind;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      want_kind = kind;
   endtask

   task automatic send_random_header();
      byte_q_type body;
      logic [3:0] words;
      logic [7:0] kind;
      int         total, pick, len, cap;
      pick = $urandom_range(99);
      if (pick < 4) begin
         // stray byte while idle
         send_item(8'($urandom()), 1'b0, 4'($urandom()));
      end else if (pick < 9) begin
         // header cut short by the next start
         words = 4'($urandom_range(1, 15));
         repeat ($urandom_range(1, words * 4 - 1)) body.push_back(8'($urandom()));
         send_header(words, body);
         body.delete();
      end
      pick = $urandom_range(99);
      if (pick < 8)
         words = 4'($urandom_range(4));
      else if (pick < 90)
         words = 4'($urandom_range(5, 8));
      else
         words = 4'($urandom_range(9, 15));
      total = words * 4;
      repeat ((total < FIXED_HEADER_BYTES_DEF) ? total : FIXED_HEADER_BYTES_DEF)
         body.push_back(8'($urandom()));
      while (body.size() < total) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            body.push_back(want_kind);
         end else if (pick < 17) begin
            body.push_back(KIND_END_OF_LIST);
         end else if (pick < 42) begin
            do kind = 8'($urandom()); while (!one_byte_option(kind));
            body.push_back(kind);
         end else if (pick < 47) begin
            body.push_back(8'($urandom()));
         end else begin
            do kind = 8'($urandom_range(2, 255)); while (one_byte_option(kind));
            body.push_back(kind);
            cap = total - body.size();
            cap = (cap > 12) ? 12 : ((cap < 2) ? 2 : cap);
            if (pick < 52)
               len = $urandom_range(1);
            else if (pick < 60)
               len = $urandom_range(2, 255);
            else
               len = $urandom_range(2, cap);
            body.push_back(8'(len));
            if (len > 2)
               repeat (len - 2) body.push_back(8'($urandom()));
         end
      end
      while (body.size() > total)
         void'(body.pop_back());
      if (total == 0)
         body.push_back(8'($urandom()));
      send_header(words, body);
   endtask

   task automatic test_special_cases();
      byte_q_type body;
      send_item(8'hFF, 1'b0, 4'hF);
      body.push_back(8'h00);
      send_header(4'd0, body);
      body.delete();
      body.push_back(8'hA5);
      send_header(4'd15, body);
      body.delete();
      body.push_back(8'h00);
      body.push_back(8'hFF);
      body.push_back(8'h55);
      body.push_back(8'hAA);
      send_header(4'd1, body);
      // nop, wanted kind, then bytes passed over after the walk has ended
      body.delete();
      for (int i = 0; i < FIXED_HEADER_BYTES_DEF; i++)
         body.push_back(i[0] ? 8'hFF : 8'h00);
      body.push_back(8'd1);
      body.push_back(WANTED_KIND_RESET);
      body.push_back(KIND_END_OF_LIST);
      body.push_back(8'd8);
      send_header(4'd6, body);
   endtask

   task automatic test_kind_setting(input logic [7:0] kind, input int n_items);
      int target;
      set_wanted_kind(kind);
      target = items_sent + n_items;
      while (items_sent < target)
         send_random_header();
   endtask

   task automatic test_receiver_stall();
      byte_q_type body;
      int         n;
      stall_req <= ~stall_req;
      repeat (40) begin
         body.delete();
         n = $urandom_range(1);
         repeat (n ? 4 : 1) body.push_back(8'($urandom()));
         send_header(4'(n), body);
      end
      drain_results();
   endtask

   task automatic test_sender_pause();
      repeat (6) begin
         send_random_header();
         drain_results();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      sender_idle_pct = 19;
      receiver_idle_pct = 60;
      test_special_cases();
      test_kind_setting(8'd0, 165);
      test_kind_setting(8'd255, 165);
      test_kind_setting(8'd1, 165);
      sender_idle_pct = 60;
      receiver_idle_pct = 19;
      test_receiver_stall();
      test_kind_setting(8'd8, 165);
      test_sender_pause();
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      test_kind_setting(8'd2, 165);
      test_kind_setting(8'($urandom()), 165);
      test_kind_setting(WANTED_KIND_RESET, 165);
      drain_results();
      if (bad_results == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
